>>> sv/umcd_pkg.sv
// Shared constants, types and command/status structs of the univariate MCD estimator.
package umcd_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int AW      = $clog2(MAX_SAMPLES);
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int VAL_W   = 16;
	localparam int SUM_W   = VAL_W + AW + 1;
	localparam int SQ_W    = 2 * VAL_W - 1 + AW;
	localparam int SCORE_W = SQ_W + CNT_W;
	localparam int FRAC_W  = 8;
	localparam int DIV_W   = SCORE_W + FRAC_W;
	localparam int DVR_W   = 2 * CNT_W;
	localparam int MEAN_W  = 24;
	localparam int VAR_W   = 39;
	localparam int H_MIN   = 2;

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic [AW-1:0]           idx;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             load;
		logic             we;
		logic             wr_new;
		logic [AW-1:0]    waddr;
		logic [AW-1:0]    wnew_idx;
		logic [AW-1:0]    raddr_a;
		logic [AW-1:0]    raddr_b;
		logic             acc_clr;
		logic             acc_add;
		logic             sl_add;
		logic             sc_mul;
		logic             sc_cmp;
		logic             sc_first;
		logic             div_start;
		logic             div_var;
		logic             take_mean;
		logic             take_var;
		logic             emit;
		logic             emit_err;
		logic             emit_last;
		logic [CNT_W-1:0] h;
	} cmd_t;

	typedef struct packed {
		logic gt;
		logic better;
		logic div_done;
	} stat_t;

endpackage

>>> sv/umcd_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module umcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> sv/umcd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module umcd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [umcd_pkg::DIV_W-1:0]  dividend,
	input  logic [umcd_pkg::DVR_W-1:0]  divisor,
	output logic                        done,
	output logic [umcd_pkg::DIV_W-1:0]  quotient
);
	import umcd_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVR_W-1:0] rem_q;
	logic [DVR_W-1:0] dvr_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVR_W:0]   trial;
	logic             fit;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fit   = trial >= {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fit ? DVR_W'(trial - {1'b0, dvr_q}) : trial[DVR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> sv/umcd_dpath.sv
// Datapath: sorted sample RAM, window sums, scoring, divider and result registers.
module umcd_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  umcd_pkg::cmd_t                    cmd,
	output umcd_pkg::stat_t                   stat,
	input  logic signed [umcd_pkg::VAL_W-1:0] sample,
	output logic                              result_valid,
	output logic [umcd_pkg::CNT_W-1:0]        member_index,
	output logic signed [umcd_pkg::MEAN_W-1:0] subset_mean,
	output logic [umcd_pkg::VAR_W-1:0]        subset_variance,
	output logic                              status,
	output logic                              run_end
);
	import umcd_pkg::*;

	logic signed [VAL_W-1:0]   v_q;
	entry_t                    wdata, rd_a, rd_b;
	logic signed [SUM_W-1:0]   s_q, best_sum_q, sum_mag;
	logic [SQ_W-1:0]           sq_q, sqa, sqb;
	logic signed [2*VAL_W-1:0] ya2, yb2;
	logic [SCORE_W-1:0]        p1_q, p2_q, score, best_score_q;
	logic signed [2*SUM_W-1:0] ssq;
	logic signed [MEAN_W-1:0]  mean_q;
	logic [VAR_W-1:0]          var_q;
	logic [DIV_W-1:0]          dividend, quo;
	logic [DVR_W-1:0]          divisor;
	logic                      div_done, mean_neg;
	logic                      valid_q, status_q, end_q;
	logic [CNT_W-1:0]          idx_q;
	logic signed [MEAN_W-1:0]  omean_q;
	logic [VAR_W-1:0]          ovar_q;

	assign wdata = cmd.wr_new ? entry_t'{val: v_q, idx: cmd.wnew_idx} : rd_a;

	umcd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SAMPLES)) u_ram (
		.clk     (clk),
		.we      (cmd.we),
		.waddr   (cmd.waddr),
		.wdata   (wdata),
		.raddr_a (cmd.raddr_a),
		.raddr_b (cmd.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign ya2   = rd_a.val * rd_a.val;
	assign yb2   = rd_b.val * rd_b.val;
	assign sqa   = {{(SQ_W-2*VAL_W){1'b0}}, ya2};
	assign sqb   = {{(SQ_W-2*VAL_W){1'b0}}, yb2};
	assign ssq   = s_q * s_q;
	assign score = p1_q - p2_q;

	assign stat.gt       = rd_a.val > v_q;
	assign stat.better   = cmd.sc_first || (score < best_score_q);
	assign stat.div_done = div_done;

	// magnitude division for the mean, sign restored afterward
	assign mean_neg = best_sum_q[SUM_W-1];
	assign sum_mag  = mean_neg ? -best_sum_q : best_sum_q;
	assign dividend = cmd.div_var ? {best_score_q, {FRAC_W{1'b0}}}
	                              : {{(DIV_W-SUM_W-FRAC_W){1'b0}}, sum_mag, {FRAC_W{1'b0}}};
	assign divisor  = cmd.div_var ? ({{CNT_W{1'b0}}, cmd.h} * {{CNT_W{1'b0}}, cmd.h - 1'b1})
	                              : {{(DVR_W-CNT_W){1'b0}}, cmd.h};

	umcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= sample;
		end
		if (cmd.acc_clr) begin
			s_q  <= '0;
			sq_q <= '0;
		end else if (cmd.acc_add) begin
			s_q  <= s_q + SUM_W'(rd_a.val);
			sq_q <= sq_q + sqa;
		end else if (cmd.sl_add) begin
			s_q  <= s_q + SUM_W'(rd_b.val) - SUM_W'(rd_a.val);
			sq_q <= sq_q + sqb - sqa;
		end
		if (cmd.sc_mul) begin
			p1_q <= {{(SCORE_W-CNT_W){1'b0}}, cmd.h} * {{(SCORE_W-SQ_W){1'b0}}, sq_q};
			p2_q <= ssq[SCORE_W-1:0];
		end
		if (cmd.sc_cmp && stat.better) begin
			best_score_q <= score;
			best_sum_q   <= s_q;
		end
		if (cmd.take_mean) begin
			mean_q <= mean_neg ? -quo[MEAN_W-1:0] : quo[MEAN_W-1:0];
		end
		if (cmd.take_var) begin
			var_q <= quo[VAR_W-1:0];
		end
		if (cmd.emit) begin
			idx_q   <= CNT_W'(rd_a.idx) + 1'b1;
			omean_q <= mean_q;
			ovar_q  <= var_q;
		end else if (cmd.emit_err) begin
			idx_q   <= '0;
			omean_q <= '0;
			ovar_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			status_q <= 1'b0;
			end_q    <= 1'b0;
		end else begin
			valid_q  <= cmd.emit | cmd.emit_err;
			status_q <= cmd.emit_err;
			end_q    <= cmd.emit_err | (cmd.emit & cmd.emit_last);
		end
	end

	assign result_valid    = valid_q;
	assign member_index    = idx_q;
	assign subset_mean     = omean_q;
	assign subset_variance = ovar_q;
	assign status          = status_q;
	assign run_end         = end_q;

endmodule

>>> sv/umcd_ctrl.sv
// Controller: insertion sort, window scan, division and result sequencing.
module umcd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       last,
	output logic                       busy,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [umcd_pkg::CNT_W-1:0] cfg_data,
	output umcd_pkg::cmd_t             cmd,
	input  umcd_pkg::stat_t            stat
);
	import umcd_pkg::*;

	typedef enum logic [3:0] {
		IDLE, INS_RD, INS_CMP, FIN, ACC_RD, ACC_ADD, SC_MUL, SC_CMP,
		SL_RD, SL_ADD, DIV_M, DIV_MW, DIV_V, DIV_VW, EM_RD, EM_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] h_q, count_q, n_q, i_q;
	logic [AW-1:0]    p_q, j_q, best_start_q;
	logic             last_q;
	logic             acc_done, scan_done, emit_done;

	assign cfg_ready = !busy;
	assign busy      = state_q != IDLE;
	assign acc_done  = (i_q + 1'b1) == h_q;
	assign scan_done = (CNT_W'(j_q) + h_q) == n_q;
	assign emit_done = (i_q + 1'b1) == h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			h_q          <= CNT_W'(H_MIN);
			count_q      <= '0;
			n_q          <= '0;
			i_q          <= '0;
			p_q          <= '0;
			j_q          <= '0;
			best_start_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				h_q <= (cfg_data < CNT_W'(H_MIN)) ? CNT_W'(H_MIN) : cfg_data;
			end
			unique case (state_q)
				IDLE: begin
					if (start) begin
						last_q  <= last;
						p_q     <= count_q[AW-1:0];
						state_q <= (count_q < CNT_W'(MAX_SAMPLES)) ? INS_RD : FIN;
					end
				end
				INS_RD: begin
					if (p_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= FIN;
					end else begin
						state_q <= INS_CMP;
					end
				end
				INS_CMP: begin
					if (stat.gt) begin
						p_q     <= p_q - 1'b1;
						state_q <= INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= FIN;
					end
				end
				FIN: begin
					if (!last_q) begin
						state_q <= IDLE;
					end else begin
						n_q     <= count_q;
						count_q <= '0;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= (h_q > count_q) ? IDLE : ACC_RD;
					end
				end
				ACC_RD: state_q <= ACC_ADD;
				ACC_ADD: begin
					i_q     <= i_q + 1'b1;
					state_q <= acc_done ? SC_MUL : ACC_RD;
				end
				SC_MUL: state_q <= SC_CMP;
				SC_CMP: begin
					if (stat.better) begin
						best_start_q <= j_q;
					end
					state_q <= scan_done ? DIV_M : SL_RD;
				end
				SL_RD: begin
					j_q     <= j_q + 1'b1;
					state_q <= SL_ADD;
				end
				SL_ADD: state_q <= SC_MUL;
				DIV_M:  state_q <= DIV_MW;
				DIV_MW: begin
					if (stat.div_done) begin
						state_q <= DIV_V;
					end
				end
				DIV_V:  state_q <= DIV_VW;
				DIV_VW: begin
					if (stat.div_done) begin
						i_q     <= '0;
						state_q <= EM_RD;
					end
				end
				EM_RD: state_q <= EM_OUT;
				EM_OUT: begin
					i_q     <= i_q + 1'b1;
					state_q <= emit_done ? IDLE : EM_RD;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.h        = h_q;
		cmd.wnew_idx = count_q[AW-1:0];
		cmd.waddr    = p_q;
		cmd.raddr_a  = p_q - 1'b1;
		unique case (state_q)
			IDLE: cmd.load = start;
			INS_RD: begin
				if (p_q == '0) begin
					cmd.we     = 1'b1;
					cmd.wr_new = 1'b1;
				end
			end
			INS_CMP: begin
				cmd.we     = 1'b1;
				cmd.wr_new = !stat.gt;
			end
			FIN: begin
				cmd.acc_clr  = 1'b1;
				cmd.emit_err = last_q && (h_q > count_q);
			end
			ACC_RD:  cmd.raddr_a = i_q[AW-1:0];
			ACC_ADD: cmd.acc_add = 1'b1;
			SC_MUL:  cmd.sc_mul  = 1'b1;
			SC_CMP: begin
				cmd.sc_cmp   = 1'b1;
				cmd.sc_first = j_q == '0;
			end
			SL_RD: begin
				cmd.raddr_a = j_q;
				cmd.raddr_b = AW'(CNT_W'(j_q) + h_q);
			end
			SL_ADD: cmd.sl_add = 1'b1;
			DIV_M:  cmd.div_start = 1'b1;
			DIV_MW: cmd.take_mean = stat.div_done;
			DIV_V: begin
				cmd.div_start = 1'b1;
				cmd.div_var   = 1'b1;
			end
			DIV_VW: begin
				cmd.div_var  = 1'b1;
				cmd.take_var = stat.div_done;
			end
			EM_RD: cmd.raddr_a = best_start_q + i_q[AW-1:0];
			EM_OUT: begin
				cmd.emit      = 1'b1;
				cmd.emit_last = emit_done;
			end
			default: ;
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == DIV_MW || state_q == DIV_VW))
		else $error("divider finished outside a wait state");

	a_shift_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == INS_CMP) |-> (p_q != '0))
		else $error("insertion compare at position zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

endmodule

>>> sv/univariate_mcd_estimator_core.sv
// Top level of the univariate MCD estimator: controller plus datapath.
// Usage:
//   Samples arrive as command words: a word (sample, last) is taken at a clock
//   edge where start is high and busy is low. last ends the sample set.
//   Each word is inserted into a stable sorted store; insertion walks down the
//   store, reading and then comparing or shifting each displaced entry.
//   After the last word the window scan runs: the first window is filled,
//   then each window position is scored and the window slides, then two
//   divisions (mean, variance) run on the shared bit-serial divider, then
//   one result is given per subset member. Results appear for one cycle
//   with result_valid high; the receiver cannot stall, so results must be
//   taken when shown. When the window exceeds the sample count one error
//   result (status 1) is given.
//   window_size is written on the cfg channel (cfg_ready follows !busy);
//   values below 2 act as 2.
//   Reset clears the sample count, sets window_size to 2 and returns to idle.
module univariate_mcd_estimator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [umcd_pkg::VAL_W-1:0]  sample,
	input  logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [umcd_pkg::CNT_W-1:0]         cfg_data,
	output logic                               result_valid,
	output logic [umcd_pkg::CNT_W-1:0]         member_index,
	output logic signed [umcd_pkg::MEAN_W-1:0] subset_mean,
	output logic [umcd_pkg::VAR_W-1:0]         subset_variance,
	output logic                               status,
	output logic                               run_end
);
	import umcd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	umcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last      (last),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	umcd_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.sample          (sample),
		.result_valid    (result_valid),
		.member_index    (member_index),
		.subset_mean     (subset_mean),
		.subset_variance (subset_variance),
		.status          (status),
		.run_end         (run_end)
	);

endmodule
